[src/curve_linear_interpolator_core_assert.svh]
// Assertion macros shared by the curve interpolator RTL.
// Expects clk and arst_n in the scope of the including module.
`ifndef CURVE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define CURVE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// Check consequent in the same cycle as the antecedent.
`define CRVI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check consequent in the cycle after the antecedent.
`define CRVI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/crvi_pkg.sv]
// Package for the curve interpolator: word types, codes and widths.
// No dependencies; used by crvi_div and the interpolator core.
`timescale 1ns / 1ps

package crvi_pkg;

	localparam int TIME_W     = 24;
	localparam int VAL_W      = 32;
	localparam int FUNC_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int ENTRY_W    = TIME_W + VAL_W;
	localparam int MAX_POINTS_DEF = 128;

	// divider: |T - ta| * |vb - va| over |tb - ta|
	localparam int NUM_W      = TIME_W + VAL_W;
	localparam int DEN_W      = TIME_W;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_ITER   = NUM_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_ITER);

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FEW     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ZEROSEG = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR    = 1'b1;

	localparam logic signed [VAL_W-1:0] VAL_ONE = 32'sh1000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [TIME_W-1:0]        time_years;
		logic signed [VAL_W-1:0]  point_value;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  result_value;
		logic [STATUS_W-1:0]      status;
	} out_word_t;

endpackage

[src/crvi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module crvi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/crvi_div.sv]
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on crvi_pkg for operand widths.
`timescale 1ns / 1ps

module crvi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [crvi_pkg::NUM_W-1:0] dividend,
	input  logic [crvi_pkg::DEN_W-1:0] divisor,
	output logic                       done,
	output logic [crvi_pkg::NUM_W-1:0] quotient
);

	logic                           run_q;
	logic                           done_q;
	logic [crvi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [crvi_pkg::NUM_W-1:0]     qd_q;
	logic [crvi_pkg::DEN_W-1:0]     rem_q;
	logic [crvi_pkg::DEN_W-1:0]     dvs_q;

	logic [crvi_pkg::NUM_W-1:0]     qd_d;
	logic [crvi_pkg::DEN_W-1:0]     rem_d;
	logic [crvi_pkg::DEN_W:0]       part;
	logic                           last;

	always_comb begin
		qd_d  = qd_q;
		rem_d = rem_q;
		part  = '0;
		for (int k = 0; k < crvi_pkg::DIV_STEPS; k++) begin
			part = {rem_d, qd_d[crvi_pkg::NUM_W-1]};
			qd_d = {qd_d[crvi_pkg::NUM_W-2:0], 1'b0};
			if (part >= {1'b0, dvs_q}) begin
				part    = part - {1'b0, dvs_q};
				qd_d[0] = 1'b1;
			end
			rem_d = part[crvi_pkg::DEN_W-1:0];
		end
	end

	assign last = (cnt_q == crvi_pkg::DIV_CNT_W'(crvi_pkg::DIV_ITER - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			qd_q  <= qd_d;
			rem_q <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;

endmodule

[src/curve_linear_interpolator_core.sv]
// Piecewise linear curve interpolator: point store, forward walk and segment math.
// Depends on crvi_pkg, crvi_ram, crvi_div and curve_linear_interpolator_core_assert.svh.
`timescale 1ns / 1ps

// Works on one word at a time. Clear, append, unused codes, a query at time
// zero and a query on an empty curve go straight to S_FIN, which loads the
// result register; the next word is taken once the block is back in S_IDLE.
// Any other query walks the point RAM one entry per cycle through its single
// registered read port, visiting at most MAX_POINTS entries (S_WALK). It then
// forms the segment differences (S_PREP), does the 24x32 multiply and starts
// the two-bit-per-cycle divider (S_MUL), waits for its 28 steps and the done
// flag (S_DIV), forms the sum and saturation (S_FIX) and loads the result
// register (S_FIN). A query that ends with too few points or a zero-length
// last segment skips the arithmetic. A new word is accepted while a finished
// result still waits in the output register; a stalled output holds the next
// result in its final state. The point store needs no clearing after reset;
// entries beyond the count are never read.
module curve_linear_interpolator_core #(
	parameter int MAX_POINTS = crvi_pkg::MAX_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  crvi_pkg::in_word_t             in_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output crvi_pkg::out_word_t            out_word,
	input  logic                           cfg_we,
	input  logic [crvi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crvi_pkg::VAL_W-1:0]     cfg_data
);

	`include "curve_linear_interpolator_core_assert.svh"

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int TW    = crvi_pkg::TIME_W;
	localparam int VW    = crvi_pkg::VAL_W;
	localparam int SUM_W = crvi_pkg::NUM_W + 2;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_WALK = 7'b0000010,
		S_PREP = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_FIX  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                count_q;
	logic signed [VW-1:0]            zero_q;
	logic signed [VW-1:0]            anchor_q;
	logic                            out_valid_q;
	crvi_pkg::out_word_t             out_q;

	logic [TW-1:0]                   t_q;
	logic [CNT_W-1:0]                iss_q;
	logic [CNT_W-1:0]                chk_q;
	logic                            vld_q;
	logic [TW-1:0]                   e_time_q;
	logic [VW-1:0]                   e_val_q;
	logic [TW-1:0]                   ta_q;
	logic [VW-1:0]                   va_q;
	logic [TW-1:0]                   tb_q;
	logic [VW-1:0]                   vb_q;
	logic [TW-1:0]                   dt_q;
	logic [VW-1:0]                   dvm_q;
	logic [crvi_pkg::DEN_W-1:0]      dm_q;
	logic                            neg_q;
	logic signed [VW-1:0]            res_q;
	logic [crvi_pkg::STATUS_W-1:0]   st_q;

	logic                            in_acc;
	logic                            out_free;
	logic                            ram_we;
	logic                            ram_re;
	logic [crvi_pkg::ENTRY_W-1:0]    ram_rdata;
	logic [TW-1:0]                   d_time;
	logic [VW-1:0]                   d_val;
	logic                            walk_last;
	logic [VW:0]                     dv;
	logic [TW:0]                     den;
	logic [crvi_pkg::NUM_W-1:0]      mul_prod;
	logic                            div_done;
	logic [crvi_pkg::NUM_W-1:0]      div_q;
	logic [SUM_W-1:0]                q_mag;
	logic [SUM_W-1:0]                q_sgn;
	logic [SUM_W-1:0]                sum;
	logic [VW-1:0]                   sum_sat;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign ram_we = in_acc && (in_word.func == crvi_pkg::FUNC_APPEND)
		&& (count_q < CNT_W'(MAX_POINTS));
	assign ram_re = (state_q == S_WALK) && (iss_q < count_q);

	crvi_ram #(
		.WIDTH (crvi_pkg::ENTRY_W),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({in_word.time_years, in_word.point_value}),
		.re    (ram_re),
		.raddr (iss_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign d_time    = ram_rdata[crvi_pkg::ENTRY_W-1:VW];
	assign d_val     = ram_rdata[VW-1:0];
	assign walk_last = (chk_q == count_q - 1'b1);

	assign dv  = {vb_q[VW-1], vb_q} - {va_q[VW-1], va_q};
	assign den = {1'b0, tb_q} - {1'b0, ta_q};

	assign mul_prod = {{VW{1'b0}}, dt_q} * {{TW{1'b0}}, dvm_q};

	crvi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_MUL),
		.dividend (mul_prod),
		.divisor  (dm_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign q_mag = {2'b00, div_q};
	assign q_sgn = neg_q ? (~q_mag + 1'b1) : q_mag;
	assign sum   = {{(SUM_W - VW){va_q[VW-1]}}, va_q} + q_sgn;

	always_comb begin
		if ((sum[SUM_W-1:VW-1] == '0) || (sum[SUM_W-1:VW-1] == '1)) begin
			sum_sat = sum[VW-1:0];
		end else if (sum[SUM_W-1]) begin
			sum_sat = crvi_pkg::VAL_MIN;
		end else begin
			sum_sat = crvi_pkg::VAL_MAX;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			zero_q      <= crvi_pkg::VAL_ONE;
			anchor_q    <= crvi_pkg::VAL_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					crvi_pkg::CFG_ZERO_TIME: zero_q   <= cfg_data;
					crvi_pkg::CFG_ANCHOR:    anchor_q <= cfg_data;
				endcase
			end
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_word.func)
							crvi_pkg::FUNC_CLEAR: begin
								count_q <= '0;
								state_q <= S_FIN;
							end
							crvi_pkg::FUNC_APPEND: begin
								if (ram_we) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= S_FIN;
							end
							crvi_pkg::FUNC_QUERY: begin
								if ((in_word.time_years != '0) && (count_q != '0)) begin
									state_q <= S_WALK;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_WALK: begin
					if (vld_q) begin
						if (d_time >= t_q) begin
							state_q <= S_PREP;
						end else if (walk_last) begin
							if ((count_q < CNT_W'(2)) || (d_time == e_time_q)) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_PREP;
							end
						end
					end
				end
				S_PREP: state_q <= S_MUL;
				S_MUL:  state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIX;
					end
				end
				S_FIX:  state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		vld_q <= ram_re;
		chk_q <= iss_q;
		if (ram_re) begin
			iss_q <= iss_q + 1'b1;
		end
		if (in_acc) begin
			t_q   <= in_word.time_years;
			iss_q <= '0;
			case (in_word.func)
				crvi_pkg::FUNC_APPEND: begin
					res_q <= '0;
					st_q  <= ram_we ? crvi_pkg::ST_OK : crvi_pkg::ST_FULL;
				end
				crvi_pkg::FUNC_QUERY: begin
					if (in_word.time_years == '0) begin
						res_q <= zero_q;
						st_q  <= crvi_pkg::ST_OK;
					end else if (count_q == '0) begin
						res_q <= '0;
						st_q  <= crvi_pkg::ST_EMPTY;
					end else begin
						res_q <= '0;
						st_q  <= crvi_pkg::ST_OK;
					end
				end
				default: begin
					res_q <= '0;
					st_q  <= crvi_pkg::ST_OK;
				end
			endcase
		end
		if ((state_q == S_WALK) && vld_q) begin
			e_time_q <= d_time;
			e_val_q  <= d_val;
			tb_q     <= d_time;
			vb_q     <= d_val;
			if ((d_time >= t_q) && (chk_q == '0)) begin
				ta_q <= '0;
				va_q <= anchor_q;
			end else begin
				ta_q <= e_time_q;
				va_q <= e_val_q;
			end
			if ((d_time < t_q) && walk_last) begin
				if (count_q < CNT_W'(2)) begin
					st_q <= crvi_pkg::ST_FEW;
				end else if (d_time == e_time_q) begin
					st_q <= crvi_pkg::ST_ZEROSEG;
				end
			end
		end
		if (state_q == S_PREP) begin
			dt_q  <= t_q - ta_q;
			dvm_q <= dv[VW] ? VW'(~dv + 1'b1) : dv[VW-1:0];
			dm_q  <= den[TW] ? TW'(~den + 1'b1) : den[TW-1:0];
			neg_q <= dv[VW] ^ den[TW];
		end
		if (state_q == S_FIX) begin
			res_q <= sum_sat;
		end
		if ((state_q == S_FIN) && out_free) begin
			out_q.result_value <= res_q;
			out_q.status       <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`CRVI_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE, "word accepted but idle")
	`CRVI_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_POINTS), "point count overflow")
	`CRVI_ASSERT_NOW(a_read_in_range, ram_re, iss_q < count_q, "read beyond stored points")
	`CRVI_ASSERT_NOW(a_div_done_state, div_done, state_q == S_DIV, "divider done outside wait")
	`CRVI_ASSERT_NEXT(a_fin_delivers, (state_q == S_FIN) && out_free,
		out_valid_q && (state_q == S_IDLE), "result not delivered")

endmodule
